[sv/sslex_pkg.sv]
// ----------------------------------------------------------------------------
// sslex_pkg: shared types and constants of the source lexer
// Token record, token kind codes, character codes and the keyword spellings.
// ----------------------------------------------------------------------------
package sslex_pkg;

	localparam int unsigned POS_BITS_DEF = 16;
	localparam int unsigned KIND_W       = 6;
	localparam int unsigned FIELD_W      = 16;
	localparam int unsigned NUM_KEYWORDS = 17;

	typedef logic [KIND_W-1:0]  kind_t;
	typedef logic [FIELD_W-1:0] field_t;

	// One token as it leaves the block.
	typedef struct packed {
		kind_t  kind;
		field_t start;
		field_t length;
		field_t line;
		logic   last;
	} token_t;

	// Token kinds.
	localparam kind_t K_LPAREN   = 6'd0;
	localparam kind_t K_RPAREN   = 6'd1;
	localparam kind_t K_LBRACE   = 6'd2;
	localparam kind_t K_RBRACE   = 6'd3;
	localparam kind_t K_SEMI     = 6'd4;
	localparam kind_t K_COMMA    = 6'd5;
	localparam kind_t K_DOT      = 6'd6;
	localparam kind_t K_MINUS    = 6'd7;
	localparam kind_t K_PLUS     = 6'd8;
	localparam kind_t K_STAR     = 6'd9;
	localparam kind_t K_SLASH    = 6'd10;
	localparam kind_t K_BANG     = 6'd11;
	localparam kind_t K_NE       = 6'd12;
	localparam kind_t K_ASSIGN   = 6'd13;
	localparam kind_t K_EQEQ     = 6'd14;
	localparam kind_t K_LT       = 6'd15;
	localparam kind_t K_LE       = 6'd16;
	localparam kind_t K_GT       = 6'd17;
	localparam kind_t K_GE       = 6'd18;
	localparam kind_t K_STRING   = 6'd19;
	localparam kind_t K_NUMBER   = 6'd20;
	localparam kind_t K_IDENT    = 6'd21;
	localparam kind_t K_KEY0     = 6'd22;
	localparam kind_t K_ERR_STR  = 6'd39;
	localparam kind_t K_ERR_BYTE = 6'd40;
	localparam kind_t K_END      = 6'd41;

	// Character codes.
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_EQUAL  = 8'h3D;
	localparam logic [7:0] CH_LESS   = 8'h3C;
	localparam logic [7:0] CH_GREATER = 8'h3E;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_USCORE = 8'h5F;

	// Keyword spellings, first character in the low byte, zero padded.
	localparam logic [63:0] KW_WORDS [NUM_KEYWORDS] = '{
		64'h0000_0000_006F_7969,  // iyo
		64'h0000_0000_0061_6D61,  // ama
		64'h0000_0069_6964_6168,  // hadii
		64'h0000_0061_6B6C_6168,  // halka
		64'h0000_6361_6261_6164,  // daabac
		64'h0000_0000_696C_6563,  // celi
		64'h0000_0000_0072_6F71,  // qor
		64'h0000_0000_0066_6564,  // def
		64'h0000_0073_7361_6C63,  // class
		64'h0000_0000_006E_616B,  // kan
		64'h0061_616C_7861_6864,  // dhaxlaa
		64'h0000_0000_0072_6F6B,  // kor
		64'h0000_0000_0072_6F66,  // for
		64'h0000_0000_656C_616B,  // kale
		64'h0000_0061_6278_6177,  // waxba
		64'h0000_0064_616C_6171,  // qalad
		64'h0000_0000_0078_6173   // sax
	};

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
			|| (c == CH_USCORE);
	endfunction

	function automatic token_t make_token(input kind_t kind, input field_t start,
			input field_t length, input field_t line);
		token_t t;
		t.kind   = kind;
		t.start  = start;
		t.length = length;
		t.line   = line;
		t.last   = 1'b0;
		return t;
	endfunction

endpackage

[sv/sslex_core.sv]
// ----------------------------------------------------------------------------
// sslex_core: scan state and per-byte token decision
// Holds the scan mode and position counters, and turns one registered request
// into zero, one or two tokens; the state steps when the request is taken.
// ----------------------------------------------------------------------------
module sslex_core #(
	parameter int unsigned POSITION_BITS = sslex_pkg::POS_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  logic [7:0]       src_byte,
	input  logic             eot,
	output logic [1:0]       tok_cnt,
	output sslex_pkg::token_t tok0,
	output sslex_pkg::token_t tok1
);
	import sslex_pkg::*;

	localparam int unsigned LW = POSITION_BITS + 1;

	typedef enum logic [3:0] {
		M_IDLE, M_BANG, M_EQ, M_LT, M_GT, M_INT, M_FRAC,
		M_WORD, M_DQ, M_SQ, M_CMT, M_DEAD
	} mode_t;

	typedef logic [POSITION_BITS-1:0] pos_t;

	function automatic pos_t sat_inc(input pos_t x);
		return (&x) ? x : x + 1'b1;
	endfunction

	mode_t       mode_q, mode_d;
	pos_t        offset_q, offset_d;
	pos_t        begin_q, begin_d;
	pos_t        line_q, line_d;
	logic [63:0] word_q, word_d;
	logic [3:0]  wcnt_q, wcnt_d;

	logic [LW-1:0] run_len;
	logic [LW-1:0] str_len;
	field_t        cur16, begin16, line16;
	kind_t         word_kind;

	// Token that a pending mode flushes, and the two-character operator it may make.
	logic   fl_v_end;
	kind_t  fl_kind;
	field_t fl_len;
	kind_t  op2_kind;
	token_t fl_tok;

	// What the byte does when it starts a fresh token.
	logic   st_v;
	kind_t  st_kind;
	mode_t  st_mode;
	logic   st_line_inc;
	token_t st_tok;

	logic   a_v, b_v, do_start;
	token_t b_tok;

	assign run_len = {1'b0, offset_q} - {1'b0, begin_q};
	assign str_len = run_len + 1'b1;
	assign cur16   = FIELD_W'(offset_q);
	assign begin16 = FIELD_W'(begin_q);
	assign line16  = FIELD_W'(line_q);

	always_comb begin
		word_kind = K_IDENT;
		for (int i = 0; i < NUM_KEYWORDS; i++) begin
			if (word_q == KW_WORDS[i]) word_kind = KIND_W'(K_KEY0 + i);
		end
	end

	always_comb begin
		fl_v_end = 1'b1;
		fl_kind  = K_NUMBER;
		fl_len   = FIELD_W'(run_len);
		op2_kind = K_NE;
		unique case (mode_q)
			M_BANG: begin
				fl_kind = K_BANG; fl_len = 16'd1; op2_kind = K_NE;
			end
			M_EQ: begin
				fl_kind = K_ASSIGN; fl_len = 16'd1; op2_kind = K_EQEQ;
			end
			M_LT: begin
				fl_kind = K_LT; fl_len = 16'd1; op2_kind = K_LE;
			end
			M_GT: begin
				fl_kind = K_GT; fl_len = 16'd1; op2_kind = K_GE;
			end
			M_INT, M_FRAC: fl_kind = K_NUMBER;
			M_WORD: fl_kind = word_kind;
			M_DQ, M_SQ: fl_kind = K_ERR_STR;
			default: fl_v_end = 1'b0;
		endcase
		fl_tok = make_token(fl_kind, begin16, fl_len, line16);
	end

	always_comb begin
		st_v        = 1'b0;
		st_kind     = K_ERR_BYTE;
		st_mode     = M_IDLE;
		st_line_inc = 1'b0;
		if (is_digit(src_byte)) begin
			st_mode = M_INT;
		end else if (is_alpha(src_byte)) begin
			st_mode = M_WORD;
		end else begin
			unique case (src_byte)
				CH_LPAREN: begin st_v = 1'b1; st_kind = K_LPAREN; end
				CH_RPAREN: begin st_v = 1'b1; st_kind = K_RPAREN; end
				CH_LBRACE: begin st_v = 1'b1; st_kind = K_LBRACE; end
				CH_RBRACE: begin st_v = 1'b1; st_kind = K_RBRACE; end
				CH_SEMI:   begin st_v = 1'b1; st_kind = K_SEMI; end
				CH_COMMA:  begin st_v = 1'b1; st_kind = K_COMMA; end
				CH_DOT:    begin st_v = 1'b1; st_kind = K_DOT; end
				CH_MINUS:  begin st_v = 1'b1; st_kind = K_MINUS; end
				CH_PLUS:   begin st_v = 1'b1; st_kind = K_PLUS; end
				CH_STAR:   begin st_v = 1'b1; st_kind = K_STAR; end
				CH_SLASH:  begin st_v = 1'b1; st_kind = K_SLASH; end
				CH_BANG:    st_mode = M_BANG;
				CH_EQUAL:   st_mode = M_EQ;
				CH_LESS:    st_mode = M_LT;
				CH_GREATER: st_mode = M_GT;
				CH_NL:      st_line_inc = 1'b1;
				CH_SPACE, CH_TAB, CH_CR: st_mode = M_IDLE;
				CH_HASH:    st_mode = M_CMT;
				CH_DQUOTE:  st_mode = M_DQ;
				CH_SQUOTE:  st_mode = M_SQ;
				default: begin
					st_v    = 1'b1;
					st_kind = K_ERR_BYTE;
					st_mode = M_DEAD;
				end
			endcase
		end
		st_tok = make_token(st_kind, cur16, 16'd1, line16);
	end

	always_comb begin
		mode_d   = mode_q;
		offset_d = sat_inc(offset_q);
		begin_d  = begin_q;
		line_d   = line_q;
		word_d   = word_q;
		wcnt_d   = wcnt_q;
		a_v      = 1'b0;
		b_v      = 1'b0;
		b_tok    = st_tok;
		do_start = 1'b0;
		if (eot) begin
			a_v      = fl_v_end;
			b_v      = 1'b1;
			b_tok    = make_token(K_END, cur16, 16'd0, line16);
			mode_d   = M_IDLE;
			offset_d = '0;
			begin_d  = '0;
			line_d   = POSITION_BITS'(1);
			word_d   = '0;
			wcnt_d   = '0;
		end else begin
			unique case (mode_q)
				M_IDLE: do_start = 1'b1;
				M_BANG, M_EQ, M_LT, M_GT: begin
					if (src_byte == CH_EQUAL) begin
						b_v    = 1'b1;
						b_tok  = make_token(op2_kind, begin16, 16'd2, line16);
						mode_d = M_IDLE;
					end else begin
						a_v      = 1'b1;
						do_start = 1'b1;
					end
				end
				M_INT: begin
					if (src_byte == CH_DOT) begin
						mode_d = M_FRAC;
					end else if (!is_digit(src_byte)) begin
						a_v      = 1'b1;
						do_start = 1'b1;
					end
				end
				M_FRAC: begin
					if (!is_digit(src_byte)) begin
						a_v      = 1'b1;
						do_start = 1'b1;
					end
				end
				M_WORD: begin
					if (is_alpha(src_byte) || is_digit(src_byte)) begin
						if (!wcnt_q[3]) begin
							word_d[{wcnt_q[2:0], 3'b000} +: 8] = src_byte;
							wcnt_d = wcnt_q + 1'b1;
						end
					end else begin
						a_v      = 1'b1;
						do_start = 1'b1;
					end
				end
				M_DQ, M_SQ: begin
					if (src_byte == ((mode_q == M_DQ) ? CH_DQUOTE : CH_SQUOTE)) begin
						b_v    = 1'b1;
						b_tok  = make_token(K_STRING, begin16, FIELD_W'(str_len), line16);
						mode_d = M_IDLE;
					end else if (src_byte == CH_NL) begin
						line_d = sat_inc(line_q);
					end
				end
				M_CMT: begin
					if (src_byte == CH_NL) begin
						line_d = sat_inc(line_q);
						mode_d = M_IDLE;
					end
				end
				M_DEAD: mode_d = M_DEAD;
				default: mode_d = M_IDLE;
			endcase
			if (do_start) begin
				b_v     = st_v;
				b_tok   = st_tok;
				mode_d  = st_mode;
				begin_d = offset_q;
				if (st_line_inc) line_d = sat_inc(line_q);
				if (st_mode == M_WORD) begin
					word_d = {56'd0, src_byte};
					wcnt_d = 4'd1;
				end
			end
		end
	end

	// Pack the flushed token ahead of the new one.
	always_comb begin
		tok_cnt   = {1'b0, a_v} + {1'b0, b_v};
		tok0      = a_v ? fl_tok : b_tok;
		tok0.last = !(a_v && b_v);
		tok1      = b_tok;
		tok1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= M_IDLE;
			offset_q <= '0;
			begin_q  <= '0;
			line_q   <= POSITION_BITS'(1);
			word_q   <= '0;
			wcnt_q   <= '0;
		end else if (take) begin
			mode_q   <= mode_d;
			offset_q <= offset_d;
			begin_q  <= begin_d;
			line_q   <= line_d;
			word_q   <= word_d;
			wcnt_q   <= wcnt_d;
		end
	end

endmodule

[sv/script_source_lexer_unit.sv]
// ----------------------------------------------------------------------------
// script_source_lexer_unit: byte-serial lexer for a small scripting language
// Takes one source byte or an end marker per request and returns tokens.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries one request per byte:
// source_byte, or end_of_text to close the source. The output channel
// (out_valid/out_ready) carries tokens as kind, start, length and line;
// last_of_run marks the final token caused by one request, and a request
// may cause none, one or two tokens.
// Path: a request accepted into the input register is decided there by the
// combinational scan logic, and its first token is loaded into the output
// register, which raises out_valid; a full output buffer can hold the
// request in the input register before that load.
// Throughput: one request per cycle while each makes at most one token and
// out_ready stays high; a request that makes two tokens holds the two-entry
// output buffer until both leave, as the port moves one token a cycle.
// Reset clears the scan state (mode idle, offset 0, line 1), the input
// register's valid flag and the output buffer's count. When the receiver
// stalls, the output buffer keeps its tokens stable, one more request waits
// in the input register, and in_ready then drops until room frees up.
// ----------------------------------------------------------------------------
module script_source_lexer_unit #(
	parameter int unsigned POSITION_BITS = sslex_pkg::POS_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  source_byte,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [5:0]  token_kind,
	output logic [15:0] token_start,
	output logic [15:0] token_length,
	output logic [15:0] token_line,
	output logic        last_of_run
);
	import sslex_pkg::*;

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eot_s1;

	// Tokens from the scan logic for the request in the input register.
	logic [1:0] tok_cnt;
	token_t     tok0, tok1;

	// Two-entry output buffer: head is on the port, tail follows it.
	token_t     head_q, tail_q;
	logic [1:0] ob_cnt_q;

	logic room, adv, load, pop;

	// The buffer can take a new pair when it is empty or its last token leaves now.
	assign room     = (ob_cnt_q == 2'd0) || ((ob_cnt_q == 2'd1) && out_ready);
	assign adv      = valid_s1 && ((tok_cnt == 2'd0) || room);
	assign load     = adv && (tok_cnt != 2'd0);
	assign pop      = out_valid && out_ready;
	assign in_ready = !valid_s1 || adv;

	sslex_core #(
		.POSITION_BITS(POSITION_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (adv),
		.src_byte (byte_s1),
		.eot      (eot_s1),
		.tok_cnt  (tok_cnt),
		.tok0     (tok0),
		.tok1     (tok1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= source_byte;
			eot_s1  <= end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_cnt_q <= 2'd0;
		end else if (load) begin
			ob_cnt_q <= tok_cnt;
		end else if (pop) begin
			ob_cnt_q <= ob_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			head_q <= tok0;
			tail_q <= tok1;
		end else if (pop) begin
			head_q <= tail_q;
		end
	end

	assign out_valid    = (ob_cnt_q != 2'd0);
	assign token_kind   = head_q.kind;
	assign token_start  = head_q.start;
	assign token_length = head_q.length;
	assign token_line   = head_q.line;
	assign last_of_run  = head_q.last;

endmodule

[sv/sslex_checker.sv]
// ----------------------------------------------------------------------------
// sslex_checker: port-level checks of the source lexer
// Watches the output channel for token shapes that the scan logic guarantees.
// ----------------------------------------------------------------------------
module sslex_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [5:0]  token_kind,
	input logic [15:0] token_start,
	input logic [15:0] token_length,
	input logic [15:0] token_line,
	input logic        last_of_run
);
	import sslex_pkg::*;

	// A stalled token stays on the port unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_kind)
			&& $stable(token_start) && $stable(token_length)
			&& $stable(token_line) && $stable(last_of_run))
		else $error("output token changed while stalled");

	// The end token is empty and closes its run.
	a_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == K_END) |-> (token_length == 16'd0) && last_of_run)
		else $error("end token with length or not last");

	// An unknown byte is one byte long and nothing follows it in its run.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (token_kind == K_ERR_BYTE) |-> (token_length == 16'd1) && last_of_run)
		else $error("unknown-byte token misshaped");

	// Two-character operators are two bytes long and the last token of their run.
	a_op2_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((token_kind == K_NE) || (token_kind == K_EQEQ)
			|| (token_kind == K_LE) || (token_kind == K_GE))
		|-> (token_length == 16'd2) && last_of_run)
		else $error("two-character operator misshaped");

endmodule

bind script_source_lexer_unit sslex_checker u_sslex_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.token_kind   (token_kind),
	.token_start  (token_start),
	.token_length (token_length),
	.token_line   (token_line),
	.last_of_run  (last_of_run)
);
